// ----- rtl/sha_pkg.sv -----
// shared types, constants and functions for the sha-256 message hasher
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    typedef enum logic [1:0] {
        SRC_MSG  = 2'd0,
        SRC_ZERO = 2'd1,
        SRC_LEN  = 2'd2
    } wsrc_t;

    // controller to datapath
    typedef struct packed {
        logic        load_byte;
        logic [5:0]  byte_pos;
        logic        round_start;
        logic        round_step;
        logic [5:0]  round_idx;
        logic        fold;
        logic        init_hash;
        wsrc_t       word_src;
        logic        pad_mark;
        logic [5:0]  mark_pos;
    } dp_cmd_t;

    localparam logic [31:0] HASH_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] PAD_MARK = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

endpackage

// ----- rtl/sha_datapath.sv -----
// sha-256 datapath: block buffer, message schedule, round registers, hash state
module sha_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  sha_pkg::dp_cmd_t  cmd,
    input  logic [7:0]        data_byte,
    input  logic [63:0]       bit_count,
    input  logic [2:0]        out_sel,
    output logic [31:0]       hash_word
);
    import sha_pkg::*;

    logic [31:0] buf_reg [16];
    logic [31:0] buf_next [16];
    logic [31:0] w_reg [16];
    logic [31:0] w_next [16];
    logic [31:0] h_reg [8];
    logic [31:0] h_next [8];
    logic [31:0] r_reg [8];
    logic [31:0] r_next [8];
    logic [31:0] w_cur, w_new, s0, s1, t1, t2, bs0, bs1, chs, mj;
    logic [31:0] blk_word [16];

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            case (cmd.word_src)
                SRC_MSG:  blk_word[i] = buf_reg[i];
                SRC_ZERO: blk_word[i] = (i == 14) ? bit_count[63:32] :
                                        (i == 15) ? bit_count[31:0] : '0;
                SRC_LEN:  blk_word[i] = (i == 14) ? bit_count[63:32] :
                                        (i == 15) ? bit_count[31:0] : buf_reg[i];
                default:  blk_word[i] = buf_reg[i];
            endcase
        end
    end

    assign w_cur = w_reg[0];
    assign s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign w_new = w_reg[0] + s0 + w_reg[9] + s1;
    assign bs1 = rotr(r_reg[4], 6) ^ rotr(r_reg[4], 11) ^ rotr(r_reg[4], 25);
    assign chs = (r_reg[4] & r_reg[5]) ^ (~r_reg[4] & r_reg[6]);
    assign t1 = r_reg[7] + bs1 + chs + ROUND_K[cmd.round_idx] + w_cur;
    assign bs0 = rotr(r_reg[0], 2) ^ rotr(r_reg[0], 13) ^ rotr(r_reg[0], 22);
    assign mj = (r_reg[0] & r_reg[1]) ^ (r_reg[0] & r_reg[2]) ^ (r_reg[1] & r_reg[2]);
    assign t2 = bs0 + mj;

    always_comb begin
        buf_next = buf_reg;
        w_next = w_reg;
        r_next = r_reg;
        h_next = h_reg;
        if (cmd.load_byte) begin
            buf_next[cmd.byte_pos[5:2]][8*(3-cmd.byte_pos[1:0]) +: 8] = data_byte;
        end
        if (cmd.pad_mark) begin
            for (int b = 0; b < 64; b++) begin
                if (b[5:0] == cmd.mark_pos) begin
                    buf_next[b/4][8*(3-b%4) +: 8] = PAD_MARK;
                end else if (b[5:0] > cmd.mark_pos) begin
                    buf_next[b/4][8*(3-b%4) +: 8] = 8'h00;
                end
            end
        end
        if (cmd.round_start) begin
            w_next = blk_word;
            r_next = h_reg;
        end else if (cmd.round_step) begin
            for (int i = 0; i < 15; i++) w_next[i] = w_reg[i+1];
            w_next[15] = w_new;
            r_next[7] = r_reg[6];
            r_next[6] = r_reg[5];
            r_next[5] = r_reg[4];
            r_next[4] = r_reg[3] + t1;
            r_next[3] = r_reg[2];
            r_next[2] = r_reg[1];
            r_next[1] = r_reg[0];
            r_next[0] = t1 + t2;
        end
        if (cmd.fold) begin
            for (int i = 0; i < 8; i++) h_next[i] = h_reg[i] + r_reg[i];
        end
        if (cmd.init_hash) begin
            h_next = HASH_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
        w_reg <= w_next;
        r_reg <= r_next;
        if (!aresetn) begin
            h_reg <= HASH_INIT;
        end else begin
            h_reg <= h_next;
        end
    end

    assign hash_word = h_reg[out_sel];

endmodule

// ----- rtl/sha_controller.sv -----
// sha-256 controller: beat intake, padding sequence, round count, digest output
module sha_controller (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sha_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          out_sel,
    output logic [63:0]         bit_count,
    output sha_pkg::dp_cmd_t    cmd
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ROUND, ST_FOLD, ST_PAD, ST_OUT
    } state_t;

    state_t      state_reg;
    logic [63:0] count_reg;
    logic [5:0]  round_reg;
    logic        fin_reg;
    logic        len_reg;
    logic        extra_reg;
    logic [2:0]  sel_reg;
    // round_start is issued on the entry cycle into ST_ROUND
    logic        start_reg;
    // marks that the padding byte has already gone into the buffer
    logic        padded_reg;
    logic [5:0]  pos;
    logic        acc;

    assign pos = count_reg[8:3];
    assign s_ready = (state_reg == ST_IDLE);
    assign acc = s_valid && s_ready;
    assign m_valid = (state_reg == ST_OUT);
    assign out_sel = sel_reg;
    assign bit_count = count_reg;

    always_comb begin
        cmd = '0;
        cmd.byte_pos = pos;
        cmd.mark_pos = pos;
        cmd.round_idx = round_reg;
        cmd.round_start = start_reg;
        cmd.word_src = len_reg ? (extra_reg ? SRC_ZERO : SRC_LEN) : SRC_MSG;
        case (state_reg)
            ST_IDLE:  cmd.load_byte = acc && s_data.byte_valid;
            ST_ROUND: cmd.round_step = !start_reg;
            ST_FOLD:  cmd.fold = 1'b1;
            ST_PAD:   cmd.pad_mark = 1'b1;
            ST_OUT:   cmd.init_hash = m_ready && (sel_reg == 3'd7);
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            round_reg <= '0;
            fin_reg <= 1'b0;
            len_reg <= 1'b0;
            extra_reg <= 1'b0;
            sel_reg <= '0;
            start_reg <= 1'b0;
            padded_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (acc) begin
                        fin_reg <= s_data.last;
                        if (s_data.byte_valid) begin
                            count_reg <= count_reg + 64'd8;
                        end
                        if (s_data.byte_valid && pos == 6'd63) begin
                            len_reg <= 1'b0;
                            extra_reg <= 1'b0;
                            start_reg <= 1'b1;
                            state_reg <= ST_ROUND;
                        end else if (s_data.last) begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    start_reg <= 1'b1;
                    state_reg <= ST_ROUND;
                    len_reg <= (pos < 6'd56);
                    extra_reg <= 1'b0;
                    padded_reg <= 1'b1;
                end
                ST_ROUND: begin
                    if (!start_reg) begin
                        round_reg <= round_reg + 6'd1;
                        if (round_reg == 6'd63) begin
                            state_reg <= ST_FOLD;
                        end
                    end
                end
                ST_FOLD: begin
                    round_reg <= '0;
                    if (!fin_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (len_reg) begin
                        sel_reg <= '0;
                        state_reg <= ST_OUT;
                    end else if (!padded_reg) begin
                        state_reg <= ST_PAD;
                    end else begin
                        len_reg <= 1'b1;
                        extra_reg <= 1'b1;
                        start_reg <= 1'b1;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        sel_reg <= sel_reg + 3'd1;
                        if (sel_reg == 3'd7) begin
                            count_reg <= '0;
                            fin_reg <= 1'b0;
                            padded_reg <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/sha256_message_hasher.sv -----
// sha-256 message hasher top level
// byte beats are taken one per cycle while idle; the beat that fills a block holds the
// input through the load, the 64 rounds and the fold; after a last beat m_valid rises once
// padding, rounds and fold are done, with another block when padding needs an extra block
// or the last beat fills a block; eight digest beats follow, one per cycle without stalls
// synchronous active-low reset restores the initial hash value and clears the bit count
module sha256_message_hasher (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sha_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sha_pkg::out_beat_t  m_data
);
    import sha_pkg::*;

    dp_cmd_t     cmd;
    logic [2:0]  out_sel;
    logic [63:0] bit_count;
    logic [31:0] hash_word;

    sha_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready),
        .out_sel(out_sel), .bit_count(bit_count), .cmd(cmd)
    );

    sha_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .data_byte(s_data.data_byte), .bit_count(bit_count),
        .out_sel(out_sel), .hash_word(hash_word)
    );

    assign m_data.digest_word = hash_word;
    assign m_data.word_index = out_sel;
    assign m_data.last_word = (out_sel == 3'd7);

    property p_no_both;
        @(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid);
    endproperty
    a_no_both: assert property (p_no_both) else $error("input and output active together");

    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
            m_valid && !m_ready |=> m_valid && $stable(out_sel);
    endproperty
    a_hold: assert property (p_hold) else $error("output beat dropped");

endmodule
